// ----- hdl/bbrs_pkg.sv -----
`timescale 1ns / 1ps
package bbrs_pkg;

  localparam int DEF_MAX_RADIUS = 63;

  localparam int RADIUS_W = 6;
  localparam int WIDTH_W  = 13;
  localparam int RECIP_W  = 17;
  localparam int PIX_W    = 16;
  localparam int SUM_W    = 23;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  typedef struct packed {
    logic [RADIUS_W-1:0] radius;
    logic [WIDTH_W-1:0]  row_width;
    logic [RECIP_W-1:0]  reciprocal;
  } cfg_t;

endpackage

// ----- hdl/box_blur_row_running_sum.sv -----
`timescale 1ns / 1ps
// Horizontal box blur of one image row with edge replication. Each input word
// is one 16-bit pixel; each output word is one blurred pixel, with tlast on the
// final pixel of a row. The first output of a row follows pixel number radius,
// and the last pixel of a row flushes the remaining radius outputs. Items are
// handled one at a time by a sequencer around a single pixel history RAM with
// registered read: a pixel that yields no output passes accept and RAM read,
// then sum update and RAM write; a pixel that yields an output goes on to the
// reciprocal multiply and the output load. At the row end each flushed output
// adds a RAM read, sum update, multiply and output load, a closing step ends
// the row whether or not anything was flushed, and a row of no more than radius
// pixels adds a padding step. A stalled output holds the sequencer in its
// output load state. The history RAM needs no clearing after reset.
// Configuration registers sit at byte addresses 0 (radius), 4 (row_width) and
// 8 (reciprocal); write them between items.
module box_blur_row_running_sum #(
  parameter int MAX_RADIUS = bbrs_pkg::DEF_MAX_RADIUS
) (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata: sample[15:0]
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,
  // m_tdata: average[15:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata,
  output logic                          m_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bbrs_pkg::PADDR_W-1:0]  paddr,
  input  logic [bbrs_pkg::PDATA_W-1:0]  pwdata,
  output logic [bbrs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import bbrs_pkg::*;

  localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
  localparam int AW        = $clog2(WIN_DEPTH);
  localparam int CW        = AW + 1;
  localparam int RCAP      = (MAX_RADIUS > 63) ? 63 : MAX_RADIUS;
  localparam int POS_W     = WIDTH_W + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(WIN_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(WIN_DEPTH - 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SUB  = 7'b0000010,
    S_PAD  = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_OUT  = 7'b0010000,
    S_FCHK = 7'b0100000,
    S_FSUB = 7'b1000000
  } state_t;

  cfg_t cfg;
  state_t state;

  logic [PIX_W-1:0]   x;
  logic [PIX_W-1:0]   first;
  logic [SUM_W-1:0]   sum;
  logic [WIDTH_W-1:0] p;
  logic [AW-1:0]      wslot;
  logic [AW-1:0]      fslot;
  logic [POS_W-1:0]   t;
  logic               flushing;
  logic               last_q;

  logic [RADIUS_W-1:0] r;
  logic [POS_W-1:0]    we_n;
  logic [POS_W-1:0]    start;
  logic                p_lt_r, p_le_2r, t_le_r, row_end, flush_empty, t_in_row;
  logic [CW-1:0]       win_c, tr_c, ws_c;
  logic [AW-1:0]       rd_norm, fslot_init, wslot_inc, fslot_inc;
  logic [RADIUS_W-1:0] pad;
  logic [SUM_W-1:0]    base_prod, pad_prod;
  logic [PIX_W-1:0]    sub_norm, sub_flush, rd_data, average;
  logic                rd_en, out_load, step_done;
  logic [AW-1:0]       rd_addr;

  bbrs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bbrs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (WIN_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (state == S_SUB),
    .wr_addr (wslot),
    .wr_data (x),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bbrs_scale u_scale (
    .clk        (clk),
    .start      (state == S_MUL),
    .sum        (sum),
    .reciprocal (cfg.reciprocal),
    .average    (average)
  );

  assign r = (cfg.radius > RADIUS_W'(RCAP)) ? RADIUS_W'(RCAP) : cfg.radius;
  // row_width of zero means a full 8192-pixel row
  assign we_n = (cfg.row_width == '0) ? POS_W'(8192) : {1'b0, cfg.row_width};

  assign p_lt_r   = p < {{(WIDTH_W-RADIUS_W){1'b0}}, r};
  assign p_le_2r  = {1'b0, p} <= {{(POS_W-RADIUS_W-1){1'b0}}, r, 1'b0};
  assign t_le_r   = t <= {{(POS_W-RADIUS_W){1'b0}}, r};
  assign row_end  = {1'b0, p} >= (we_n - POS_W'(1));
  assign start    = p_lt_r ? '0
                  : {1'b0, p} - {{(POS_W-RADIUS_W){1'b0}}, r} + POS_W'(1);
  assign flush_empty = !(start < we_n);
  assign t_in_row    = t < we_n;

  // slot arithmetic modulo the history depth; 2r+1 never exceeds the depth
  assign win_c = CW'({r, 1'b1});
  assign tr_c  = CW'({r, 1'b0});
  assign ws_c  = {1'b0, wslot};
  assign rd_norm = (ws_c >= win_c) ? AW'(ws_c - win_c) : AW'(ws_c + DEPTH_C - win_c);
  assign fslot_init = (start <= {{(POS_W-RADIUS_W){1'b0}}, r}) ? '0
                    : (ws_c >= tr_c) ? AW'(ws_c - tr_c) : AW'(ws_c + DEPTH_C - tr_c);
  assign wslot_inc = (wslot == LAST_SLOT) ? '0 : wslot + AW'(1);
  assign fslot_inc = (fslot == LAST_SLOT) ? '0 : fslot + AW'(1);

  assign base_prod = SUM_W'({1'b0, r} + 7'd1) * SUM_W'(s_tdata);
  assign pad       = r - RADIUS_W'(1) - p[RADIUS_W-1:0];
  assign pad_prod  = SUM_W'(pad) * SUM_W'(x);

  // left of the row the leaving pixel is the first one
  assign sub_norm  = p_le_2r ? first : rd_data;
  assign sub_flush = t_le_r ? first : rd_data;

  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = fslot;
    if (state == S_IDLE) begin
      rd_en   = s_tvalid;
      rd_addr = rd_norm;
    end else if (state == S_FCHK) begin
      rd_en   = t_in_row;
    end
  end

  assign step_done = ((state == S_SUB) && p_lt_r && !row_end)
                  || (out_load && !flushing && !row_end)
                  || ((state == S_FCHK) && !t_in_row);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      p        <= '0;
      wslot    <= '0;
      sum      <= '0;
      first    <= '0;
      flushing <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            x <= s_tdata;
            if (p == '0) begin
              first <= s_tdata;
              sum   <= base_prod;
            end
            state <= S_SUB;
          end
        end
        S_SUB: begin
          if (p_lt_r) begin
            sum   <= sum + SUM_W'(x);
            state <= row_end ? S_PAD : S_IDLE;
          end else begin
            sum    <= sum + SUM_W'(x) - SUM_W'(sub_norm);
            last_q <= row_end && flush_empty;
            state  <= S_MUL;
          end
        end
        S_PAD: begin
          // row ended before the window filled: pad with the last pixel
          sum      <= sum + pad_prod;
          t        <= '0;
          fslot    <= '0;
          flushing <= 1'b1;
          state    <= S_FCHK;
        end
        S_MUL: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            m_tvalid <= 1'b1;
            m_tdata  <= average;
            m_tlast  <= last_q;
            if (flushing) begin
              t <= t + POS_W'(1);
              if (!t_le_r) begin
                fslot <= fslot_inc;
              end
              state <= S_FCHK;
            end else if (row_end) begin
              t        <= start;
              fslot    <= fslot_init;
              flushing <= 1'b1;
              state    <= S_FCHK;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_FCHK: begin
          state <= t_in_row ? S_FSUB : S_IDLE;
        end
        S_FSUB: begin
          sum    <= sum + SUM_W'(x) - SUM_W'(sub_flush);
          last_q <= (t == (we_n - POS_W'(1)));
          state  <= S_MUL;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (step_done) begin
        flushing <= 1'b0;
        if (row_end) begin
          p     <= '0;
          wslot <= '0;
        end else begin
          p     <= p + WIDTH_W'(1);
          wslot <= wslot_inc;
        end
      end
    end
  end

endmodule

// ----- hdl/bbrs_ram.sv -----
`timescale 1ns / 1ps
module bbrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 127
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/bbrs_regs.sv -----
`timescale 1ns / 1ps
module bbrs_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bbrs_pkg::PADDR_W-1:0]  paddr,
  input  logic [bbrs_pkg::PDATA_W-1:0]  pwdata,
  output logic [bbrs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output bbrs_pkg::cfg_t                cfg
);
  import bbrs_pkg::*;

  typedef enum logic [1:0] {
    REG_RADIUS     = 2'd0,
    REG_ROW_WIDTH  = 2'd1,
    REG_RECIPROCAL = 2'd2
  } reg_idx_t;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 6'd1;
  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 13'd640;
  localparam logic [RECIP_W-1:0]  RECIP_RST  = 17'd21845;

  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radius     <= RADIUS_RST;
      cfg.row_width  <= WIDTH_RST;
      cfg.reciprocal <= RECIP_RST;
    end else if (wr) begin
      case (idx)
        REG_RADIUS:     cfg.radius     <= pwdata[RADIUS_W-1:0];
        REG_ROW_WIDTH:  cfg.row_width  <= pwdata[WIDTH_W-1:0];
        REG_RECIPROCAL: cfg.reciprocal <= pwdata[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RADIUS:     prdata = PDATA_W'(cfg.radius);
      REG_ROW_WIDTH:  prdata = PDATA_W'(cfg.row_width);
      REG_RECIPROCAL: prdata = PDATA_W'(cfg.reciprocal);
      default:        prdata = '0;
    endcase
  end

endmodule

// ----- hdl/bbrs_scale.sv -----
`timescale 1ns / 1ps
module bbrs_scale (
  input  logic                         clk,
  input  logic                         start,
  input  logic [bbrs_pkg::SUM_W-1:0]   sum,
  input  logic [bbrs_pkg::RECIP_W-1:0] reciprocal,
  output logic [bbrs_pkg::PIX_W-1:0]   average
);
  import bbrs_pkg::*;

  localparam int PROD_W = SUM_W + RECIP_W;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] rounded;

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= PROD_W'(sum) * PROD_W'(reciprocal);
    end
  end

  // round half up, then clamp to 16 bits
  assign rounded = prod + PROD_W'(32768);
  assign average = (|rounded[PROD_W-1:32]) ? {PIX_W{1'b1}} : rounded[31:16];

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

  localparam int TOP_RADIUS  = bbrs_pkg::DEF_MAX_RADIUS;
  localparam int HIST_DEPTH  = 2 * TOP_RADIUS + 1;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYC  = 8;
  localparam int RAND_ITEMS  = 480;

  typedef enum int {
    REG_RADIUS    = 0,
    REG_ROW_WIDTH = 1,
    REG_RECIP     = 2
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] average;
    logic        last_of_row;
  } blur_word_t;

  // Tracks the row blur and holds the averages still owed by the block.
  class row_blur_board;
    logic [5:0]  rad;
    logic [12:0] width_reg;
    logic [16:0] recip;
    logic [15:0] hist [HIST_DEPTH];
    logic [22:0] acc;
    logic [15:0] lead_pix;
    logic [12:0] col;
    blur_word_t  due_averages [$];
    int          errors;

    function new();
      rad       = 6'd1;
      width_reg = 13'd640;
      recip     = 17'd21845;
      acc       = '0;
      lead_pix  = '0;
      col       = '0;
      errors    = 0;
      foreach (hist[j]) hist[j] = '0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_RADIUS:    rad = val[5:0];
        REG_ROW_WIDTH: width_reg = val[12:0];
        REG_RECIP:     recip = val[16:0];
        default: ;
      endcase
    endfunction

    function logic [15:0] scaled(logic [22:0] s);
      logic [39:0] prod;
      prod = ({17'd0, s} * {23'd0, recip} + 40'd32768) >> 16;
      return (prod > 40'd65535) ? 16'hFFFF : prod[15:0];
    endfunction

    function void push_avg();
      blur_word_t w;
      w.average     = scaled(acc);
      w.last_of_row = 1'b0;
      due_averages.push_back(w);
    endfunction

    function void note_pixel(logic [15:0] x);
      int r, we, p, t, start, pos, base;
      logic [15:0] sub;
      blur_word_t w;
      r    = (int'(rad) > TOP_RADIUS) ? TOP_RADIUS : int'(rad);
      we   = (width_reg == 0) ? 8192 : int'(width_reg);
      p    = int'(col);
      base = due_averages.size();
      if (p == 0) begin
        lead_pix = x;
        acc      = 23'((r + 1) * int'(x));
      end
      if (p < r) begin
        hist[p % HIST_DEPTH] = x;
        acc = acc + 23'(x);
      end else begin
        t   = p - r;
        sub = (t <= r) ? lead_pix : hist[(t - r - 1) % HIST_DEPTH];
        hist[p % HIST_DEPTH] = x;
        acc = acc + 23'(x) - 23'(sub);
        push_avg();
      end
      if (p >= we - 1) begin
        if (p < r) begin
          // row ended before the window filled: pad with the last pixel
          acc   = acc + 23'((r - 1 - p) * int'(x));
          start = 0;
        end else begin
          start = p - r + 1;
        end
        for (t = start; t < we; t++) begin
          pos = t - r - 1;
          sub = (pos < 0) ? lead_pix : hist[pos % HIST_DEPTH];
          acc = acc + 23'(x) - 23'(sub);
          push_avg();
        end
        if (due_averages.size() > base) begin
          w = due_averages.pop_back();
          w.last_of_row = 1'b1;
          due_averages.push_back(w);
        end
        col = '0;
      end else begin
        col = col + 13'd1;
      end
    endfunction

    function void check_average(logic [15:0] avg, logic lst);
      blur_word_t want;
      if (due_averages.size() == 0) begin
        $error("unexpected word: average %0d last_of_row %0b", avg, lst);
        errors++;
        return;
      end
      want = due_averages.pop_front();
      if (avg !== want.average) begin
        $error("average: expected %0d, got %0d", want.average, avg);
        errors++;
      end
      if (lst !== want.last_of_row) begin
        $error("last_of_row: expected %0b, got %0b", want.last_of_row, lst);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [bbrs_pkg::PADDR_W-1:0] paddr  = '0;
  logic [bbrs_pkg::PDATA_W-1:0] pwdata = '0;
  logic [bbrs_pkg::PDATA_W-1:0] prdata;
  logic        pready;

  row_blur_board board;
  bit          calm = 1'b0;
  int          hold_cnt = 0;
  int          quiet = 0;

  box_blur_row_running_sum dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int k;
    if (calm) return 0;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // sink side: random back-pressure
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      hold_cnt <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.note_pixel(s_tdata);
      if (m_tvalid && m_tready) board.check_average(m_tdata, m_tlast);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bbrs_pkg::PADDR_W'(4 * int'(idx));
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic write_cfg(input int r, input int w, input int rc);
    reg_write(REG_RADIUS, r);
    reg_write(REG_ROW_WIDTH, w);
    reg_write(REG_RECIP, rc);
  endtask

  // valid stays up across back-to-back words; lowered only for a gap
  task automatic send_pixel(input logic [15:0] x, input int gap);
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    do @(posedge clk); while (!s_tready);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the source until every owed word is out, then let the pipe go quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.due_averages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  initial begin
    int sent, i, r, win, w, rc, rows, row, mid, k;
    board = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset radius and reciprocal, short row width
    reg_write(REG_ROW_WIDTH, 3);
    send_pixel(16'hFFFF, pick_gap());
    send_pixel(16'hFFFF, pick_gap());
    send_pixel(16'h0000, pick_gap());
    settle();
    // radius zero, one-pixel rows, unit scale
    write_cfg(0, 1, 65536);
    send_pixel(16'hFFFF, pick_gap());
    send_pixel(16'h0000, pick_gap());
    settle();
    // saturation
    write_cfg(1, 2, 65536);
    send_pixel(16'hFFFF, pick_gap());
    send_pixel(16'hFFFF, pick_gap());
    settle();
    // widest window on a short row
    write_cfg(63, 5, 516);
    send_pixel(16'd100, pick_gap());
    send_pixel(16'hFFFF, pick_gap());
    send_pixel(16'h0000, pick_gap());
    send_pixel(16'd40000, pick_gap());
    send_pixel(16'd7, pick_gap());
    settle();
    // row exactly one window wide
    write_cfg(2, 5, 13107);
    send_pixel(16'd1, pick_gap());
    send_pixel(16'd2, pick_gap());
    send_pixel(16'd3, pick_gap());
    send_pixel(16'd4, pick_gap());
    send_pixel(16'hFFFF, pick_gap());
    settle();
    // row ends before the first output, zero scale
    write_cfg(3, 2, 0);
    send_pixel(16'd9, pick_gap());
    send_pixel(16'hFFFF, pick_gap());
    settle();
    // radius grows in the middle of a row
    write_cfg(1, 6, 21845);
    send_pixel(16'd500, pick_gap());
    send_pixel(16'd60000, pick_gap());
    send_pixel(16'd1234, pick_gap());
    settle();
    reg_write(REG_RADIUS, 3);
    send_pixel(16'd8, pick_gap());
    send_pixel(16'hFFFF, pick_gap());
    send_pixel(16'd321, pick_gap());
    settle();

    sent = 0;
    while (sent < RAND_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      k = $urandom_range(0, 11);
      if (k == 0) r = 63;
      else if (k == 1) r = $urandom_range(8, 62);
      else r = $urandom_range(0, 4);
      win = 2 * r + 1;
      if ($urandom_range(0, 7) == 0) w = $urandom_range(1, win);
      else w = win + $urandom_range(0, 24);
      case ($urandom_range(0, 9))
        0: rc = 0;
        1: rc = 65536;
        2: rc = $urandom_range(0, 65536);
        default: rc = (65536 + win / 2) / win;
      endcase
      write_cfg(r, w, rc);
      rows = (r > 8) ? 1 : $urandom_range(1, 3);
      for (row = 0; row < rows; row++) begin
        mid = ($urandom_range(0, 7) == 0 && w > 2) ? $urandom_range(1, w - 2) : -1;
        for (i = 0; i < w; i++) begin
          if (i == mid) begin
            settle();
            case ($urandom_range(0, 2))
              0: reg_write(REG_RADIUS, $urandom_range(0, 63));
              1: reg_write(REG_RECIP, $urandom_range(0, 65536));
              default: begin
                // zero width means 8192; put the real width back before the end
                reg_write(REG_ROW_WIDTH, 0);
                send_pixel(pick_sample(), pick_gap());
                sent++;
                i++;
                settle();
                reg_write(REG_ROW_WIDTH, w);
              end
            endcase
          end
          send_pixel(pick_sample(), pick_gap());
          sent++;
        end
      end
      settle();
    end

    calm = 1'b0;
    settle();
    repeat (16) @(posedge clk);
    if (board.errors == 0 && board.due_averages.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/bbrs_pkg.sv
hdl/bbrs_ram.sv
hdl/bbrs_regs.sv
hdl/bbrs_scale.sv
hdl/box_blur_row_running_sum.sv
bench/tb_top.sv
